FILE: src/assert_macros.svh
// Assertion macros of the radix digit block, used by its top-level module.
// Depends on nothing; the using module supplies the clock and reset signals.
// SYNTH selects empty bodies for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SIRD_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SIRD_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SIRD_ASSERT(name, prop, msg)
`define SIRD_ASSERT_ALWAYS(name, prop, msg)
`endif
`endif

FILE: src/sird_pkg.sv
// Package of the radix digit block: character codes, register map and the
// structs passed between its modules. Depends on nothing.
`default_nettype none
package sird_pkg;
   localparam int NUM_SYMBOLS = 16;
   localparam int SYM_IDX_W   = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 64;
   localparam int RADIX_W     = 5;

   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_NONE  = 8'h00;
   localparam logic [RADIX_W-1:0] MIN_RADIX = 5'd2;

   localparam logic [1:0] REG_RADIX  = 2'd0;
   localparam logic [1:0] REG_SYM_LO = 2'd1;
   localparam logic [1:0] REG_SYM_HI = 2'd2;

   localparam logic [RADIX_W-1:0] RADIX_RESET  = 5'd2;
   localparam logic [63:0]        SYM_LO_RESET = 64'h3130;
   localparam logic [63:0]        SYM_HI_RESET = 64'h0;

   typedef struct packed {
      logic                             ok;
      logic [RADIX_W-1:0]               radix;
      logic [NUM_SYMBOLS-1:0][7:0]      symbols;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic run;
   } div_ctrl_type;

   typedef struct packed {
      logic done;
      logic quot_nz;
   } div_stat_type;
endpackage
`default_nettype wire

FILE: src/sird_csr.sv
// Configuration registers of the radix digit block and the registered check
// of the radix and the symbol set. Depends on sird_pkg.
`default_nettype none
module sird_csr import sird_pkg::*; #(
   parameter int MAX_RADIX = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output      logic [CSR_DATA_W-1:0] prdata,
   output      logic                  pready,
   output      cfg_type               cfg
);
   logic [RADIX_W-1:0] radix_ff;
   logic [63:0]        sym_lo_ff;
   logic [63:0]        sym_hi_ff;
   logic               ok_ff;
   logic               ok_in;
   logic               wr_en;
   logic [1:0]         reg_idx;
   logic [NUM_SYMBOLS-1:0][7:0] sym;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[4:3];
   assign sym     = {sym_hi_ff, sym_lo_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RADIX_RESET;
         sym_lo_ff <= SYM_LO_RESET;
         sym_hi_ff <= SYM_HI_RESET;
         ok_ff     <= 1'b1;
      end else begin
         ok_ff <= ok_in;
         if (wr_en) begin
            unique case (reg_idx)
               REG_RADIX:  radix_ff  <= pwdata[RADIX_W-1:0];
               REG_SYM_LO: sym_lo_ff <= pwdata;
               REG_SYM_HI: sym_hi_ff <= pwdata;
               default:    ;
            endcase
         end
      end
   end

   always_comb begin
      ok_in = (radix_ff >= MIN_RADIX) && (radix_ff <= RADIX_W'(MAX_RADIX));
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (RADIX_W'(i) < radix_ff &&
             (sym[i] == CHAR_PLUS || sym[i] == CHAR_MINUS)) begin
            ok_in = 1'b0;
         end
         for (int j = i + 1; j < NUM_SYMBOLS; j++) begin
            if (RADIX_W'(j) < radix_ff && sym[i] == sym[j]) begin
               ok_in = 1'b0;
            end
         end
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RADIX:  prdata = {{(CSR_DATA_W-RADIX_W){1'b0}}, radix_ff};
         REG_SYM_LO: prdata = sym_lo_ff;
         REG_SYM_HI: prdata = sym_hi_ff;
         default:    prdata = '0;
      endcase
   end

   assign cfg.ok      = ok_ff;
   assign cfg.radix   = radix_ff;
   assign cfg.symbols = sym;
endmodule
`default_nettype wire

FILE: src/sird_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, the quotient
// replacing the dividend in place. Depends on sird_pkg.
`default_nettype none
module sird_divider import sird_pkg::*; #(
   parameter int VALUE_BITS = 32,
   parameter int DIG_W      = 4
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire div_ctrl_type          ctrl,
   input  wire logic [VALUE_BITS-1:0] value,
   input  wire logic [DIG_W:0]        radix,
   output      logic [DIG_W-1:0]      digit,
   output      div_stat_type          stat
);
   localparam int CNT_W = $clog2(VALUE_BITS);

   logic [VALUE_BITS-1:0] mag_ff;
   logic [DIG_W-1:0]      rem_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic                  qnz_ff;
   logic [VALUE_BITS-1:0] mag_in;
   logic [DIG_W:0]        trial;
   logic [DIG_W:0]        diff;
   logic                  qbit;

   assign mag_in = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
   assign trial  = {rem_ff, mag_ff[VALUE_BITS-1]};
   assign qbit   = (trial >= radix);
   assign diff   = trial - radix;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.run) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(VALUE_BITS - 1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff <= mag_in;
      end else if (busy_ff && !ctrl.run) begin
         mag_ff <= {mag_ff[VALUE_BITS-2:0], qbit};
      end
      if (ctrl.run) begin
         cnt_ff <= '0;
         rem_ff <= '0;
         qnz_ff <= 1'b0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         rem_ff <= qbit ? diff[DIG_W-1:0] : trial[DIG_W-1:0];
         qnz_ff <= qnz_ff | qbit;
      end
   end

   assign digit        = rem_ff;
   assign stat.done    = done_ff;
   assign stat.quot_nz = qnz_ff;
endmodule
`default_nettype wire

FILE: src/sird_stack.sv
// Digit stack as a shift line: push enters at the head, pop shifts toward
// the head. Depends on nothing.
`default_nettype none
module sird_stack #(
   parameter int DEPTH = 32,
   parameter int DIG_W = 4
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic                       pop,
   input  wire logic [DIG_W-1:0]           push_digit,
   output      logic [DIG_W-1:0]           top_digit,
   output      logic [$clog2(DEPTH+1)-1:0] count
);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][DIG_W-1:0] ent_ff;
   logic [CNT_W-1:0]            count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (push) begin
         count_ff <= count_ff + 1'b1;
      end else if (pop) begin
         count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[0] <= push_digit;
         for (int i = 1; i < DEPTH; i++) begin
            ent_ff[i] <= ent_ff[i-1];
         end
      end else if (pop) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            ent_ff[i] <= ent_ff[i+1];
         end
      end
   end

   assign top_digit = ent_ff[0];
   assign count     = count_ff;
endmodule
`default_nettype wire

FILE: src/signed_integer_to_radix_digits.sv
// Top level: signed integer to text in a configured radix, one character
// per item. Depends on sird_pkg, sird_csr, sird_divider, sird_stack and assert_macros.svh.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_value
//   rsp      out        rsp_valid/rsp_stall   rsp_out_char, rsp_last, rsp_base_error
//   csr      in/out     APB write/read        64-bit registers at 0, 8, 16
//
// One item at a time. The bit-serial divider produces the digits least
// significant first and pushes them onto the digit stack; the sequencer then
// sends the sign, if negative, and pops the digits. An invalid radix or symbol
// set gives one error item instead. Reset is synchronous and empties the block;
// rsp_stall holds the output register and the sequencer waits on it.
`default_nettype none
`include "assert_macros.svh"
module signed_integer_to_radix_digits import sird_pkg::*; #(
   parameter int MAX_RADIX  = 16,
   parameter int VALUE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [VALUE_BITS-1:0] req_value,
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic [7:0]            rsp_out_char,
   output      logic                  rsp_last,
   output      logic                  rsp_base_error,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output      logic [CSR_DATA_W-1:0] csr_prdata,
   output      logic                  csr_pready
);
   localparam int DIG_W   = $clog2(MAX_RADIX);
   localparam int STACK_W = $clog2(VALUE_BITS + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_DIV   = 3'd2;
   localparam logic [2:0] S_SIGN  = 3'd3;
   localparam logic [2:0] S_POP   = 3'd4;

   cfg_type              cfg;
   div_ctrl_type         div_ctrl;
   div_stat_type         div_stat;
   logic [DIG_W-1:0]     div_digit;
   logic [DIG_W-1:0]     top_digit;
   logic [STACK_W-1:0]   stack_count;
   logic                 push;
   logic                 pop;
   logic                 out_free;

   logic [2:0]           state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           char_ff, char_in;
   logic                 last_ff, last_in;
   logic                 err_ff, err_in;

   sird_csr #(.MAX_RADIX(MAX_RADIX)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   sird_divider #(.VALUE_BITS(VALUE_BITS), .DIG_W(DIG_W)) u_divider (
      .clock (clock),
      .reset (reset),
      .ctrl  (div_ctrl),
      .value (req_value),
      .radix (cfg.radix[DIG_W:0]),
      .digit (div_digit),
      .stat  (div_stat)
   );

   sird_stack #(.DEPTH(VALUE_BITS), .DIG_W(DIG_W)) u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (pop),
      .push_digit (div_digit),
      .top_digit  (top_digit),
      .count      (stack_count)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in     = state_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      char_in      = char_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      div_ctrl     = '0;
      push         = 1'b0;
      pop          = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               div_ctrl.load = 1'b1;
               neg_in        = req_value[VALUE_BITS-1];
               state_in      = S_START;
            end
         end
         S_START: begin
            if (cfg.ok) begin
               div_ctrl.run = 1'b1;
               state_in     = S_DIV;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_NONE;
               last_in      = 1'b1;
               err_in       = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               push = 1'b1;
               if (div_stat.quot_nz) begin
                  div_ctrl.run = 1'b1;
               end else begin
                  state_in = S_SIGN;
               end
            end
         end
         S_SIGN: begin
            if (!neg_ff) begin
               state_in = S_POP;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               char_in      = CHAR_MINUS;
               last_in      = 1'b0;
               err_in       = 1'b0;
               state_in     = S_POP;
            end
         end
         S_POP: begin
            if (out_free) begin
               pop          = 1'b1;
               rsp_valid_in = 1'b1;
               char_in      = cfg.symbols[SYM_IDX_W'(top_digit)];
               last_in      = (stack_count == STACK_W'(1));
               err_in       = 1'b0;
               if (stack_count == STACK_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      char_ff <= char_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_char   = char_ff;
   assign rsp_last       = last_ff;
   assign rsp_base_error = err_ff;

   `SIRD_ASSERT(a_err_is_last, rsp_valid && rsp_base_error |-> rsp_last, "error item without last")
   `SIRD_ASSERT(a_no_overflow, push |-> stack_count < STACK_W'(VALUE_BITS), "digit stack overflow")
   `SIRD_ASSERT(a_done_in_div, div_stat.done |-> state_ff == S_DIV, "divider done outside divide")
   `SIRD_ASSERT(a_pop_nonempty, state_ff == S_POP |-> stack_count != '0, "pop from empty stack")
   `SIRD_ASSERT_ALWAYS(a_reset_clears, reset |=> !rsp_valid && state_ff == S_IDLE, "reset not clean")
endmodule
`default_nettype wire
